FILE: rtl/core/ccs_pkg.sv
// Package for the C comment stripper: character codes, scan modes and the
// result bundle passed from the scanner to the output queue.
// Depends on nothing.
package ccs_pkg;

    localparam logic [7:0] CH_NEWLINE    = 8'd10;
    localparam logic [7:0] CH_QUOTE      = 8'd34;
    localparam logic [7:0] CH_APOSTROPHE = 8'd39;
    localparam logic [7:0] CH_STAR       = 8'd42;
    localparam logic [7:0] CH_SLASH      = 8'd47;
    localparam logic [7:0] CH_BACKSLASH  = 8'd92;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_CODE   = 2'd0,
        MODE_STRING = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } scan_mode_t;

    // Results caused by one item: count is 0, 1 or 2; byte_a goes out first.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
    } res_bundle_t;

    function automatic logic is_escaper(input logic [7:0] b);
        is_escaper = (b == CH_BACKSLASH) || (b == CH_APOSTROPHE);
    endfunction

endpackage

FILE: rtl/core/c_comment_stripper.sv
// Top level of the C comment stripper: stream ports, scanner and a two-deep
// queue of result bundles. Depends on ccs_pkg and ccs_scan.
//
//  channel | direction | tdata          | tuser       | tlast
//  s_      | in        | [7:0] in_byte  | [0] command | -
//  m_      | out       | [7:0] out_byte | -           | last_of_run
//
// An item is scanned in the cycle it is accepted; its results are registered in
// the head bundle, or in the skid bundle behind a busy head, and leave one byte per cycle while m_ is not stalled.
// One item per cycle is sustained while m_ is not stalled and each item gives at most one result;
// an item that gives two results holds the output until both bytes are taken.
// s_tready falls only when the second bundle slot is taken, which happens when
// m_ is stalled or when the head bundle still holds two bytes.
// aresetn is synchronous and active low; it clears the scan state and queue.
module c_comment_stripper (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic [0:0] s_tuser,   // [0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);
    import ccs_pkg::*;

    res_bundle_t step_res;
    logic        accept;
    logic        push;

    res_bundle_t head_reg, head_next;
    logic        head_vld_reg, head_vld_next;
    res_bundle_t skid_reg, skid_next;
    logic        skid_vld_reg, skid_vld_next;
    logic        pop_byte;
    logic        pop_done;

    assign s_tready = !skid_vld_reg;
    assign accept   = s_tvalid && s_tready;

    ccs_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (accept),
        .command (s_tuser[0]),
        .in_byte (s_tdata),
        .result  (step_res)
    );

    assign push     = accept && (step_res.count != 2'd0);
    assign pop_byte = head_vld_reg && m_tready;
    assign pop_done = pop_byte && (head_reg.count != 2'd2);

    // Output stage: head bundle drives the port, skid bundle waits behind it.
    assign m_tvalid = head_vld_reg;
    assign m_tdata  = head_reg.byte_a;
    assign m_tlast  = (head_reg.count != 2'd2);

    // Queue update.
    always_comb begin
        head_next     = head_reg;
        head_vld_next = head_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (!head_vld_reg || pop_done) begin
            if (skid_vld_reg) begin
                head_next     = skid_reg;
                head_vld_next = 1'b1;
                skid_next     = step_res;
                skid_vld_next = push;
            end else begin
                head_next     = step_res;
                head_vld_next = push;
            end
        end else begin
            if (pop_byte) begin
                head_next.count  = 2'd1;
                head_next.byte_a = head_reg.byte_b;
            end
            if (push) begin
                skid_next     = step_res;
                skid_vld_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            head_vld_reg <= head_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: rtl/core/ccs_scan.sv
// Per-byte scanner of the comment stripper: holds the scan state and works
// out the results caused by one item. Depends on ccs_pkg.
module ccs_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_en,
    input  logic                 command,
    input  logic [7:0]           in_byte,
    output ccs_pkg::res_bundle_t result
);
    import ccs_pkg::*;

    scan_mode_t mode_reg, mode_next;
    logic       slash_reg, slash_next;
    logic       star_reg, star_next;
    logic       esc_reg, esc_next;

    // Next state of the scanner.
    always_comb begin
        mode_next  = mode_reg;
        slash_next = slash_reg;
        star_next  = star_reg;
        esc_next   = esc_reg;
        if (command == CMD_END) begin
            mode_next  = MODE_CODE;
            slash_next = 1'b0;
            star_next  = 1'b0;
            esc_next   = 1'b0;
        end else begin
            case (mode_reg)
                MODE_BLOCK: begin
                    if (in_byte == CH_STAR) begin
                        star_next = 1'b1;
                    end else if (in_byte == CH_SLASH && star_reg) begin
                        mode_next = MODE_CODE;
                        star_next = 1'b0;
                        esc_next  = 1'b0;
                    end else begin
                        star_next = 1'b0;
                    end
                end
                MODE_LINE: begin
                    if (in_byte == CH_NEWLINE) begin
                        mode_next = MODE_CODE;
                        esc_next  = 1'b0;
                    end
                end
                MODE_STRING: begin
                    if (in_byte == CH_NEWLINE) begin
                        mode_next = MODE_CODE;
                        esc_next  = 1'b0;
                    end else begin
                        if (in_byte == CH_QUOTE && !esc_reg) begin
                            mode_next = MODE_CODE;
                        end
                        esc_next = is_escaper(in_byte);
                    end
                end
                default: begin
                    slash_next = 1'b0;
                    if (slash_reg && in_byte == CH_SLASH) begin
                        mode_next = MODE_LINE;
                        esc_next  = 1'b0;
                    end else if (slash_reg && in_byte == CH_STAR) begin
                        mode_next = MODE_BLOCK;
                        star_next = 1'b0;
                        esc_next  = 1'b0;
                    end else if (in_byte == CH_SLASH) begin
                        slash_next = 1'b1;
                        esc_next   = 1'b0;
                    end else if (in_byte == CH_NEWLINE) begin
                        esc_next = 1'b0;
                    end else begin
                        // A flushed slash clears the escape marker first.
                        if (in_byte == CH_QUOTE && !(esc_reg && !slash_reg)) begin
                            mode_next = MODE_STRING;
                        end
                        esc_next = is_escaper(in_byte);
                    end
                end
            endcase
        end
    end

    // Results caused by the item.
    always_comb begin
        result.count  = 2'd0;
        result.byte_a = in_byte;
        result.byte_b = in_byte;
        if (command == CMD_END) begin
            result.byte_a = CH_SLASH;
            result.count  = slash_reg ? 2'd1 : 2'd0;
        end else begin
            case (mode_reg)
                MODE_BLOCK, MODE_LINE: begin
                    if (in_byte == CH_NEWLINE) begin
                        result.count = 2'd1;
                    end
                end
                MODE_STRING: begin
                    result.count = 2'd1;
                end
                default: begin
                    if (slash_reg) begin
                        if (in_byte != CH_SLASH && in_byte != CH_STAR) begin
                            result.byte_a = CH_SLASH;
                            result.count  = 2'd2;
                        end
                    end else if (in_byte != CH_SLASH) begin
                        result.count = 2'd1;
                    end
                end
            endcase
        end
    end

    // State registers, advanced once per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_CODE;
            slash_reg <= 1'b0;
            star_reg  <= 1'b0;
            esc_reg   <= 1'b0;
        end else if (step_en) begin
            mode_reg  <= mode_next;
            slash_reg <= slash_next;
            star_reg  <= star_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for c_comment_stripper: directed and random C-like
// text drives the input stream, and a predictor checks every output item.
// Depends on ccs_pkg and the c_comment_stripper RTL.
module testbench;
    import ccs_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PERCENT = 34;

    // One source item, with a flag that holds it back until all text is out.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       drain;
    } src_item_t;

    // One item of stripped text.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } text_out_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic [0:0] s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    src_item_t  source_q[$];
    text_out_t  stripped_q[$];
    src_item_t  next_item;
    text_out_t  want;
    int         items_sent = 0;
    int         fail_count = 0;
    int         cycle_count = 0;
    logic       pause_next = 1'b0;
    logic       calm;

    // Predictor state.
    scan_mode_t mode = MODE_CODE;
    logic       slash_pending = 1'b0;
    logic       star_pending = 1'b0;
    logic       quote_escaped = 1'b0;

    c_comment_stripper uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // A stretch of several hundred items runs with no idling on either side.
    assign calm = (items_sent >= 600) && (items_sent < 900);

    // Works out the stripped text for one accepted item and queues it.
    function automatic void strip_predict(input logic cmd, input logic [7:0] b);
        logic [7:0] outs[2];
        int         n;
        logic       taken;
        text_out_t  res_entry;
        n = 0;
        taken = 1'b0;
        if (cmd == CMD_END) begin
            if (slash_pending) begin
                outs[n] = CH_SLASH;
                n++;
            end
            mode = MODE_CODE;
            slash_pending = 1'b0;
            star_pending = 1'b0;
            quote_escaped = 1'b0;
        end else begin
            case (mode)
                MODE_BLOCK: begin
                    if (b == CH_NEWLINE) begin
                        outs[n] = b;
                        n++;
                        star_pending = 1'b0;
                    end else if (b == CH_STAR) begin
                        star_pending = 1'b1;
                    end else if (b == CH_SLASH && star_pending) begin
                        mode = MODE_CODE;
                        star_pending = 1'b0;
                        quote_escaped = 1'b0;
                    end else begin
                        star_pending = 1'b0;
                    end
                end
                MODE_LINE: begin
                    if (b == CH_NEWLINE) begin
                        outs[n] = b;
                        n++;
                        mode = MODE_CODE;
                        quote_escaped = 1'b0;
                    end
                end
                MODE_STRING: begin
                    outs[n] = b;
                    n++;
                    if (b == CH_NEWLINE) begin
                        mode = MODE_CODE;
                        quote_escaped = 1'b0;
                    end else begin
                        if (b == CH_QUOTE && !quote_escaped)
                            mode = MODE_CODE;
                        quote_escaped = (b == CH_BACKSLASH) || (b == CH_APOSTROPHE);
                    end
                end
                default: begin
                    // A held slash is resolved by the byte that follows it.
                    if (slash_pending) begin
                        slash_pending = 1'b0;
                        quote_escaped = 1'b0;
                        if (b == CH_SLASH) begin
                            mode = MODE_LINE;
                            taken = 1'b1;
                        end else if (b == CH_STAR) begin
                            mode = MODE_BLOCK;
                            star_pending = 1'b0;
                            taken = 1'b1;
                        end else begin
                            outs[n] = CH_SLASH;
                            n++;
                        end
                    end
                    if (!taken) begin
                        if (b == CH_SLASH) begin
                            slash_pending = 1'b1;
                            quote_escaped = 1'b0;
                        end else begin
                            outs[n] = b;
                            n++;
                            if (b == CH_NEWLINE) begin
                                quote_escaped = 1'b0;
                            end else begin
                                if (b == CH_QUOTE && !quote_escaped)
                                    mode = MODE_STRING;
                                quote_escaped = (b == CH_BACKSLASH) || (b == CH_APOSTROPHE);
                            end
                        end
                    end
                end
            endcase
        end
        for (int i = 0; i < n; i++) begin
            res_entry.data = outs[i];
            res_entry.last = (i == n - 1);
            stripped_q = {stripped_q, res_entry};
        end
    endfunction

    // Queues one text byte; a pause request rides on the next item queued.
    task automatic add_byte(input logic [7:0] b);
        src_item_t entry;
        entry.cmd = CMD_BYTE;
        entry.data = b;
        entry.drain = pause_next;
        source_q = {source_q, entry};
        pause_next = 1'b0;
    endtask

    // End of text; the byte field carries random junk.
    task automatic add_end();
        src_item_t entry;
        entry.cmd = CMD_END;
        entry.data = 8'($urandom_range(0, 255));
        entry.drain = pause_next;
        source_q = {source_q, entry};
        pause_next = 1'b0;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(32, 126));
    endfunction

    // Mostly well-formed C fragments with random content, plus some noise.
    task automatic add_fragment();
        int         pick;
        int         len;
        int         sel;
        logic [7:0] odd[6];
        odd = '{CH_SLASH, CH_STAR, CH_QUOTE, CH_APOSTROPHE, CH_BACKSLASH, CH_NEWLINE};
        pick = $urandom_range(0, 99);
        len = $urandom_range(0, 6);
        if (pick < 18) begin
            for (int i = 0; i <= len; i++)
                add_byte(printable());
        end else if (pick < 30) begin
            add_text("//");
            for (int i = 0; i < len; i++)
                add_byte(($urandom_range(0, 3) == 0) ? odd[$urandom_range(0, 4)] : printable());
            add_byte(CH_NEWLINE);
        end else if (pick < 44) begin
            // Block comment, which may hold stars, slashes and newlines.
            add_text("/*");
            for (int i = 0; i < len; i++)
                add_byte(($urandom_range(0, 2) == 0) ? odd[$urandom_range(0, 5)] : printable());
            if ($urandom_range(0, 3) == 0)
                add_byte(CH_NEWLINE);
            add_text("*/");
        end else if (pick < 56) begin
            add_byte(CH_QUOTE);
            for (int i = 0; i < len; i++) begin
                sel = $urandom_range(0, 5);
                if (sel == 0) begin
                    add_byte(CH_BACKSLASH);
                    add_byte(CH_QUOTE);
                end else if (sel == 1) begin
                    add_byte(odd[$urandom_range(0, 1)]);
                end else begin
                    add_byte(printable());
                end
            end
            if ($urandom_range(0, 7) != 0)
                add_byte(CH_QUOTE);
        end else if (pick < 61) begin
            add_byte(CH_APOSTROPHE);
            add_byte(($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_BACKSLASH);
            add_byte(CH_APOSTROPHE);
        end else if (pick < 68) begin
            add_byte(CH_NEWLINE);
        end else if (pick < 74) begin
            add_byte(odd[$urandom_range(0, 1)]);
        end else if (pick < 80) begin
            add_end();
        end else if (pick < 90) begin
            for (int i = 0; i <= len / 2; i++)
                add_byte(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i <= len / 2; i++)
                add_byte(odd[$urandom_range(0, 5)]);
        end
    endtask

    // Cycle counter and timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("** c_comment_stripper: FAILED **");
            $finish;
        end
    end

    // Driver: predicts each accepted item and presents the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                strip_predict(s_tuser[0], s_tdata);
            if (!s_tvalid || s_tready) begin
                if (source_q.size() != 0
                    && !(source_q[0].drain && stripped_q.size() != 0)
                    && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    next_item = source_q.pop_front();
                    s_tdata <= next_item.data;
                    s_tuser <= next_item.cmd;
                    s_tvalid <= 1'b1;
                    items_sent <= items_sent + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted output item against the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (stripped_q.size() == 0) begin
                    $error("unexpected item: out_byte %0d, last_of_run %0b", m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = stripped_q.pop_front();
                    if (m_tdata !== want.data) begin
                        $error("out_byte: expected %0d, got %0d", want.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    initial begin
        int target;
        // Directed text: byte extremes, slash held before a newline and a quote,
        // comment marks inside a string, escaped quotes, end of text with and
        // without a held slash, a block comment whose opening star cannot close
        // it and whose star at a line end does not pair, code after the close.
        add_byte(8'h00);
        add_byte(8'hFF);
        add_text("/\n");
        add_text("/\"/*\"");
        add_text("\\\"/");
        add_end();
        add_end();
        add_text("/*/*\n/*/\"");
        add_text("x\n//\n");
        add_text("'\"/*");
        add_end();

        // Random part, with a pause for all output at the start and midway.
        pause_next = 1'b1;
        target = source_q.size() + RANDOM_ITEMS;
        while (source_q.size() < target) begin
            if (source_q.size() > target - RANDOM_ITEMS / 2
                && source_q.size() < target - RANDOM_ITEMS / 2 + 8)
                pause_next = 1'b1;
            add_fragment();
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (source_q.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (stripped_q.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        if (fail_count == 0 && stripped_q.size() == 0) begin
            $display("** c_comment_stripper: PASSED **");
        end else begin
            $display("** c_comment_stripper: FAILED **");
        end
        $finish;
    end

endmodule
